@@ sv/lsp_pkg.sv @@
// Package for the line sensor position block: widths, command struct,
// position table, reciprocal table and popcount helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lsp_pkg;

    localparam int BITS_W   = 8;
    localparam int CNT_W    = 4;
    localparam int IDX_W    = 3;
    localparam int SUM_W    = 15;
    localparam int MAG_W    = 14;
    localparam int RCP_W    = 18;
    localparam int RCP_SH   = 17;
    localparam int PROD_W   = 32;
    localparam int MID_W    = 12;
    localparam int OFS_W    = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_HIGH       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDPOINT_OFFSET = 2'd2;

    localparam logic [CNT_W-1:0]  SEVEN_SENSORS = 4'd7;
    localparam logic [BITS_W-1:0] MASK_SEVEN    = 8'h7f;
    localparam logic [BITS_W-1:0] MASK_EIGHT    = 8'hff;

    typedef struct packed {
        logic             load;
        logic             accum;
        logic [IDX_W-1:0] idx;
        logic             mul;
        logic             corr;
        logic             out_load;
    } lsp_cmd_t;

    function automatic logic signed [SUM_W-1:0] lsp_pos(input logic seven,
                                                       input logic [IDX_W-1:0] idx);
        logic signed [SUM_W-1:0] p;
        p = '0;
        if (seven)
        begin
            case (idx)
                3'd0:    p = -15'sd4299;
                3'd1:    p = -15'sd2866;
                3'd2:    p = -15'sd1433;
                3'd3:    p = 15'sd0;
                3'd4:    p = 15'sd1433;
                3'd5:    p = 15'sd2866;
                3'd6:    p = 15'sd4299;
                default: p = 15'sd0;
            endcase
        end
        else
        begin
            case (idx)
                3'd0:    p = -15'sd6700;
                3'd1:    p = -15'sd4400;
                3'd2:    p = -15'sd2400;
                3'd3:    p = -15'sd700;
                3'd4:    p = 15'sd700;
                3'd5:    p = 15'sd2400;
                3'd6:    p = 15'sd4400;
                default: p = 15'sd6700;
            endcase
        end
        return p;
    endfunction

    // floor(2^17 / d) for d of 1 to 8; 0 for any other d
    function automatic logic [RCP_W-1:0] lsp_recip(input logic [CNT_W-1:0] d);
        logic [RCP_W-1:0] r;
        case (d)
            4'd1:    r = 18'd131072;
            4'd2:    r = 18'd65536;
            4'd3:    r = 18'd43690;
            4'd4:    r = 18'd32768;
            4'd5:    r = 18'd26214;
            4'd6:    r = 18'd21845;
            4'd7:    r = 18'd18724;
            4'd8:    r = 18'd16384;
            default: r = 18'd0;
        endcase
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] lsp_ones(input logic [BITS_W-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < BITS_W; i++)
        begin
            n = n + CNT_W'(v[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

@@ sv/line_sensor_position_top.sv @@
// Line sensor position: one result per sample, offset in signed hundredths.
// Steps: position sum over the bits one at a time, reciprocal multiply,
// correction, output load; a new sample is taken only after output load.
// The output register lets the next item enter while a result waits.
// rst_n clears control and previous bits; config resets to 8 sensors,
// dark high, midpoint 0. Depends on lsp_pkg, lsp_ctrl, lsp_dp.
`timescale 1ns / 1ps
`default_nettype none

module line_sensor_position_top
    import lsp_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_wdata,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [BITS_W-1:0]       raw_bits,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [BITS_W-1:0]            line_bits,
    output logic [CNT_W-1:0]             active_count,
    output logic [CNT_W-1:0]             change_count,
    output logic                         line_found,
    output logic signed [OFS_W-1:0]      offset_centi
);

    lsp_cmd_t cmd;

    lsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    lsp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .raw_bits     (raw_bits),
        .cmd          (cmd),
        .line_bits    (line_bits),
        .active_count (active_count),
        .change_count (change_count),
        .line_found   (line_found),
        .offset_centi (offset_centi)
    );

endmodule

`default_nettype wire

@@ sv/lsp_ctrl.sv @@
// Controller for the line sensor position block: sequences accept,
// bit-serial accumulate, divide and output load. Depends on lsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsp_ctrl
    import lsp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  wire logic     out_stall,
    output lsp_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCUM,
        S_MUL,
        S_CORR,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM:
            begin
                cmd.accum = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(BITS_W - 1))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CORR;
            end
            S_CORR:
            begin
                cmd.corr   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ sv/lsp_dp.sv @@
// Datapath for the line sensor position block: configuration registers,
// normalization, counts, position sum, divide by count, output registers.
// Depends on lsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsp_dp
    import lsp_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_wdata,
    input  wire logic [BITS_W-1:0]       raw_bits,
    input  wire lsp_cmd_t                cmd,
    output logic [BITS_W-1:0]            line_bits,
    output logic [CNT_W-1:0]             active_count,
    output logic [CNT_W-1:0]             change_count,
    output logic                         line_found,
    output logic signed [OFS_W-1:0]      offset_centi
);

    logic [CNT_W-1:0]         sensor_count_reg;
    logic                     dark_high_reg;
    logic [MID_W-1:0]         mid_reg;
    logic [BITS_W-1:0]        prev_reg;

    logic [BITS_W-1:0]        bits_reg;
    logic [CNT_W-1:0]         active_reg;
    logic [CNT_W-1:0]         change_reg;
    logic                     seven_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic [MAG_W-1:0]         qest_reg;
    logic [MAG_W-1:0]         quot_reg;

    logic [BITS_W-1:0]        line_bits_reg;
    logic [CNT_W-1:0]         active_count_reg;
    logic [CNT_W-1:0]         change_count_reg;
    logic                     line_found_reg;
    logic signed [OFS_W-1:0]  offset_reg;

    logic                     seven;
    logic [BITS_W-1:0]        used;
    logic [BITS_W-1:0]        norm;
    logic [MAG_W-1:0]         mag;
    logic [PROD_W-1:0]        prod;
    logic [RCP_W-1:0]         qd;
    logic [RCP_W-1:0]         rem;
    logic [MAG_W-1:0]         quot;
    logic signed [OFS_W-1:0]  qs;
    logic signed [OFS_W-1:0]  mid_ext;
    logic signed [OFS_W-1:0]  offset;

    always_comb
    begin
        seven = (sensor_count_reg == SEVEN_SENSORS);
        used  = seven ? MASK_SEVEN : MASK_EIGHT;
        norm  = raw_bits & used;
        if (!dark_high_reg)
        begin
            norm = norm ^ used;
        end

        mag  = sum_reg[SUM_W-1] ? MAG_W'(-sum_reg) : sum_reg[MAG_W-1:0];
        prod = PROD_W'(mag) * PROD_W'(lsp_recip(active_reg));

        qd   = RCP_W'(qest_reg) * RCP_W'(active_reg);
        rem  = RCP_W'(mag_reg) - qd;
        quot = (rem >= RCP_W'(active_reg)) ? qest_reg + 1'b1 : qest_reg;

        qs      = neg_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg});
        mid_ext = OFS_W'($signed(mid_reg));
        if (active_reg == '0 || sum_reg == '0)
        begin
            offset = '0;
        end
        else
        begin
            offset = qs - mid_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_count_reg <= 4'd8;
            dark_high_reg    <= 1'b1;
            mid_reg          <= '0;
            prev_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SENSOR_COUNT:    sensor_count_reg <= cfg_wdata[CNT_W-1:0];
                    CFG_DARK_HIGH:       dark_high_reg    <= cfg_wdata[0];
                    CFG_MIDPOINT_OFFSET: mid_reg          <= cfg_wdata[MID_W-1:0];
                    default:             ;
                endcase
            end
            if (cmd.load)
            begin
                prev_reg <= norm;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bits_reg   <= norm;
            active_reg <= lsp_ones(norm);
            change_reg <= lsp_ones(norm ^ prev_reg);
            seven_reg  <= seven;
            sum_reg    <= '0;
        end
        if (cmd.accum && bits_reg[cmd.idx])
        begin
            sum_reg <= sum_reg + lsp_pos(seven_reg, cmd.idx);
        end
        if (cmd.mul)
        begin
            qest_reg <= prod[MAG_W+RCP_SH-1:RCP_SH];
        end
        if (cmd.corr)
        begin
            quot_reg <= quot;
        end
        if (cmd.out_load)
        begin
            line_bits_reg    <= bits_reg;
            active_count_reg <= active_reg;
            change_count_reg <= change_reg;
            line_found_reg   <= (active_reg != '0);
            offset_reg       <= offset;
        end
    end

    // magnitude and sign are taken once the sum is complete
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            mag_reg <= mag;
            neg_reg <= sum_reg[SUM_W-1];
        end
    end

    assign line_bits    = line_bits_reg;
    assign active_count = active_count_reg;
    assign change_count = change_count_reg;
    assign line_found   = line_found_reg;
    assign offset_centi = offset_reg;

endmodule

`default_nettype wire

@@ bench/line_sensor_position_top_test.sv @@
// Self-checking bench for line_sensor_position_top: a directed table, then random
// phases under several register settings, with random gaps and stalls on both sides.
// Depends on lsp_pkg and the line_sensor_position_top RTL.
`timescale 1ns / 1ps

module line_sensor_position_top_test;
    import lsp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_PAUSE  = 16;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 240;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic { ROW_CFG, ROW_SAMPLE } row_kind_t;

    typedef struct packed {
        logic [BITS_W-1:0]       line_bits;
        logic [CNT_W-1:0]        active_count;
        logic [CNT_W-1:0]        change_count;
        logic                    line_found;
        logic signed [OFS_W-1:0] offset_centi;
    } sample_result_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_W-1:0]       data;
        logic [BITS_W-1:0]      raw;
        logic                   has_literal;
        sample_result_t         literal;
    } stim_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_wdata = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [BITS_W-1:0]       raw_bits = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [BITS_W-1:0]       line_bits;
    logic [CNT_W-1:0]        active_count;
    logic [CNT_W-1:0]        change_count;
    logic                    line_found;
    logic signed [OFS_W-1:0] offset_centi;

    logic [CNT_W-1:0]        model_count = 4'd8;
    logic                    model_dark = 1'b1;
    logic [MID_W-1:0]        model_mid = '0;
    logic [BITS_W-1:0]       model_prev = '0;

    sample_result_t          expected_results[$];
    stim_row_t               directed_rows[$];
    sample_result_t          wanted;
    int                      mismatches = 0;
    int                      cycle_count = 0;
    logic                    send_burst = 1'b0;
    logic                    recv_burst = 1'b0;
    logic                    long_hold_armed = 1'b0;

    line_sensor_position_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .raw_bits     (raw_bits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_bits    (line_bits),
        .active_count (active_count),
        .change_count (change_count),
        .line_found   (line_found),
        .offset_centi (offset_centi)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("line_sensor_position_top_test NOT OK");
            $finish;
        end
    end

    function automatic int sensor_weight(input logic seven, input int i);
        int w;
        w = 0;
        if (seven)
        begin
            case (i)
                0:       w = -4299;
                1:       w = -2866;
                2:       w = -1433;
                4:       w = 1433;
                5:       w = 2866;
                6:       w = 4299;
                default: w = 0;
            endcase
        end
        else
        begin
            case (i)
                0:       w = -6700;
                1:       w = -4400;
                2:       w = -2400;
                3:       w = -700;
                4:       w = 700;
                5:       w = 2400;
                6:       w = 4400;
                7:       w = 6700;
                default: w = 0;
            endcase
        end
        return w;
    endfunction

    function automatic sample_result_t predict_sample(input logic [BITS_W-1:0] raw);
        sample_result_t    r;
        logic              seven;
        logic [BITS_W-1:0] used;
        logic [BITS_W-1:0] bits;
        logic [BITS_W-1:0] diff;
        int                sum;
        int                count;
        int                changes;
        int                mid;
        int                offset;
        int                i;
        seven = (model_count == SEVEN_SENSORS);
        used = seven ? MASK_SEVEN : MASK_EIGHT;
        bits = raw & used;
        if (!model_dark)
        begin
            bits = bits ^ used;
        end
        diff = bits ^ model_prev;
        sum = 0;
        count = 0;
        changes = 0;
        for (i = 0; i < BITS_W; i++)
        begin
            if (bits[i])
            begin
                count = count + 1;
                sum = sum + sensor_weight(seven, i);
            end
            if (diff[i])
            begin
                changes = changes + 1;
            end
        end
        model_prev = bits;
        mid = $signed(model_mid);
        offset = 0;
        if (count != 0 && sum != 0)
        begin
            offset = sum / count - mid;
        end
        r.line_bits = bits;
        r.active_count = count[CNT_W-1:0];
        r.change_count = changes[CNT_W-1:0];
        r.line_found = (count != 0);
        r.offset_centi = offset[OFS_W-1:0];
        return r;
    endfunction

    function automatic logic [BITS_W-1:0] draw_raw();
        logic [BITS_W-1:0] run;
        int                width;
        int                start;
        width = $urandom_range(1, 3);
        start = $urandom_range(0, BITS_W - 1);
        run = ((1 << width) - 1) << start;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(0, 255);
            5, 6:          return run;
            7:             return 8'h01 << start;
            8:             return ~run;
            default:       return $urandom_range(0, 1) ? MASK_EIGHT : 8'h00;
        endcase
    endfunction

    task automatic add_cfg_row(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        stim_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.index = index;
        row.data = data;
        directed_rows.push_back(row);
    endtask

    task automatic add_sample_row(input logic [BITS_W-1:0] raw);
        stim_row_t row;
        row = '0;
        row.kind = ROW_SAMPLE;
        row.raw = raw;
        directed_rows.push_back(row);
    endtask

    task automatic add_literal_row(input logic [BITS_W-1:0] raw, input logic [BITS_W-1:0] bits,
                                   input int active, input int changes,
                                   input logic found, input int offset);
        stim_row_t row;
        row = '0;
        row.kind = ROW_SAMPLE;
        row.raw = raw;
        row.has_literal = 1'b1;
        row.literal.line_bits = bits;
        row.literal.active_count = active[CNT_W-1:0];
        row.literal.change_count = changes[CNT_W-1:0];
        row.literal.line_found = found;
        row.literal.offset_centi = offset[OFS_W-1:0];
        directed_rows.push_back(row);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            CFG_SENSOR_COUNT:    model_count = data[CNT_W-1:0];
            CFG_DARK_HIGH:       model_dark = data[0];
            CFG_MIDPOINT_OFFSET: model_mid = data[MID_W-1:0];
            default:             ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic send_item(input stim_row_t row);
        int             gap;
        sample_result_t predicted;
        if ($urandom_range(0, 49) == 0)
        begin
            send_burst = ~send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_bits <= row.raw;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predicted = predict_sample(row.raw);
        expected_results.push_back(row.has_literal ? row.literal : predicted);
    endtask

    initial
    begin
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_armed)
            begin
                long_hold_armed = 1'b0;
                hold = LONG_HOLD;
            end
            else
            begin
                if ($urandom_range(0, 49) == 0)
                begin
                    recv_burst = ~recv_burst;
                end
                hold = recv_burst ? 0 : $urandom_range(0, 8);
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected item: line_bits %h offset %0d", $time,
                         line_bits, offset_centi);
                mismatches = mismatches + 1;
            end
            else
            begin
                wanted = expected_results.pop_front();
                if (line_bits !== wanted.line_bits)
                begin
                    $display("%0t: line_bits expected %h actual %h", $time,
                             wanted.line_bits, line_bits);
                    mismatches = mismatches + 1;
                end
                if (active_count !== wanted.active_count)
                begin
                    $display("%0t: active_count expected %0d actual %0d", $time,
                             wanted.active_count, active_count);
                    mismatches = mismatches + 1;
                end
                if (change_count !== wanted.change_count)
                begin
                    $display("%0t: change_count expected %0d actual %0d", $time,
                             wanted.change_count, change_count);
                    mismatches = mismatches + 1;
                end
                if (line_found !== wanted.line_found)
                begin
                    $display("%0t: line_found expected %b actual %b", $time,
                             wanted.line_found, line_found);
                    mismatches = mismatches + 1;
                end
                if (offset_centi !== wanted.offset_centi)
                begin
                    $display("%0t: offset_centi expected %0d actual %0d", $time,
                             wanted.offset_centi, offset_centi);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    initial
    begin
        stim_row_t        row;
        int               phase;
        int               n;
        logic [CFG_W-1:0] count_val;
        logic [CFG_W-1:0] dark_val;
        logic [CFG_W-1:0] mid_val;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_literal_row(8'h00, 8'h00, 0, 0, 1'b0, 0);
        add_literal_row(8'hff, 8'hff, 8, 8, 1'b1, 0);
        add_literal_row(8'h01, 8'h01, 1, 7, 1'b1, -6700);
        add_literal_row(8'h80, 8'h80, 1, 2, 1'b1, 6700);
        add_literal_row(8'h18, 8'h18, 2, 3, 1'b1, 0);
        add_sample_row(8'h03);
        add_sample_row(8'haa);
        add_cfg_row(CFG_MIDPOINT_OFFSET, 12'h7ff);
        add_sample_row(8'h01);
        add_sample_row(8'h18);
        add_sample_row(8'h00);
        add_cfg_row(CFG_MIDPOINT_OFFSET, 12'h800);
        add_sample_row(8'h80);
        add_sample_row(8'h55);
        add_cfg_row(CFG_DARK_HIGH, 12'h000);
        add_sample_row(8'hff);
        add_sample_row(8'h00);
        add_sample_row(8'hfe);
        add_cfg_row(CFG_SENSOR_COUNT, 12'd7);
        add_cfg_row(CFG_MIDPOINT_OFFSET, 12'h000);
        add_sample_row(8'h80);
        add_sample_row(8'h7f);
        add_cfg_row(CFG_DARK_HIGH, 12'hfff);
        add_sample_row(8'hff);
        add_sample_row(8'h01);
        add_sample_row(8'h40);
        add_sample_row(8'h80);
        add_sample_row(8'h07);
        add_cfg_row(CFG_SENSOR_COUNT, 12'd15);
        add_cfg_row(CFG_UNUSED, 12'hfff);
        add_sample_row(8'h81);
        add_cfg_row(CFG_SENSOR_COUNT, 12'd0);
        add_sample_row(8'h80);
        add_cfg_row(CFG_UNUSED, 12'h000);
        add_cfg_row(CFG_SENSOR_COUNT, 12'd8);
        add_sample_row(8'hc3);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                drain_block();
                write_reg(directed_rows[i].index, directed_rows[i].data);
            end
            else
            begin
                send_item(directed_rows[i]);
            end
        end

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_block();
            if (phase == 0 || phase == 2)
            begin
                count_val = 12'd7;
            end
            else if (phase == 1)
            begin
                count_val = 12'd8;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0, 1:    count_val = 12'd7;
                    2, 3:    count_val = 12'd8;
                    default: count_val = $urandom_range(0, 15);
                endcase
            end
            if (phase == 0)
            begin
                dark_val = 12'd1;
            end
            else if (phase == 1)
            begin
                dark_val = 12'd0;
            end
            else
            begin
                dark_val = $urandom_range(0, 4095);
            end
            if (phase == 0)
            begin
                mid_val = 12'h7ff;
            end
            else if (phase == 1)
            begin
                mid_val = 12'h800;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                mid_val = $urandom_range(0, 1) ? 12'sd2000 : -12'sd2000;
            end
            else
            begin
                mid_val = $urandom_range(0, 4095);
            end
            write_reg(CFG_SENSOR_COUNT, count_val);
            write_reg(CFG_DARK_HIGH, dark_val);
            write_reg(CFG_MIDPOINT_OFFSET, mid_val);
            if ($urandom_range(0, 1) == 1)
            begin
                write_reg(CFG_UNUSED, $urandom_range(0, 4095));
            end
            if (phase == 1 || phase == 5)
            begin
                long_hold_armed = 1'b1;
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                row = '0;
                row.kind = ROW_SAMPLE;
                row.raw = draw_raw();
                send_item(row);
            end
        end

        drain_block();
        if (mismatches == 0)
        begin
            $display("line_sensor_position_top_test OK");
        end
        else
        begin
            $display("line_sensor_position_top_test NOT OK");
        end
        $finish;
    end

endmodule
